// File: design/ldf_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; every other design file imports this package.
package ldf_pkg;

    // Payload buffer depth and the width of the saturating payload counter.
    localparam int BUF_DEPTH = 128;
    localparam int PC_W      = $clog2(BUF_DEPTH + 1);

    // Fixed field widths.
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 7;
    localparam int POS_W   = 17;
    localparam int LEN_W   = 16;

    // Frame positions of the header bytes.
    localparam logic [POS_W-1:0] POS_LEN_LSB = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN_MSB = POS_W'(3);
    localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(4);
    localparam logic [POS_W-1:0] HEADER_SIZE = POS_W'(5);

    // Reset values of the delimiter registers.
    localparam logic [BYTE_W-1:0] START_ONE_RST = 8'd10;
    localparam logic [BYTE_W-1:0] START_TWO_RST = 8'd250;
    localparam logic [BYTE_W-1:0] STOP_RST      = 8'd11;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_START_ONE = 2'd0,
        CFG_START_TWO = 2'd1,
        CFG_STOP      = 2'd2
    } t_cfg_idx;

    // Parser stages.
    typedef enum logic [1:0] {
        ST_HUNT1   = 2'd0,
        ST_HUNT2   = 2'd1,
        ST_LEN_LSB = 2'd2,
        ST_BODY    = 2'd3
    } t_stage;

    // Result item kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

endpackage

// File: design/ldf_if.sv
// Valid/ready channel interfaces of the deframer: byte input, result output
// and configuration write. Depends on ldf_pkg.

// Received byte channel.
interface ldf_byte_if;
    import ldf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel: payload bytes and end-of-frame reports.
interface ldf_res_if;
    import ldf_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         out_kind;
    logic [BYTE_W-1:0]  out_byte;
    logic [INDEX_W-1:0] out_index;
    logic               truncated;

    modport source (output valid, output out_kind, output out_byte,
                    output out_index, output truncated, input ready);
    modport sink   (input valid, input out_kind, input out_byte,
                    input out_index, input truncated, output ready);
endinterface

// Configuration write channel.
interface ldf_cfg_if;
    import ldf_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        index;
    logic [BYTE_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/length_prefixed_frame_deframer_top.sv
// Top level of the length-prefixed frame deframer: parser state, delimiter
// registers and the result register. Depends on ldf_pkg and ldf_if.sv.
// A result is registered and appears on o_out in the cycle after its byte is accepted.
// Throughput: one byte per cycle; i_in.ready is high while the result register
// is empty or its request is being taken, so only output backpressure stalls.
// Reset (synchronous, active low) returns the parser to hunting, clears the
// counters and the result valid flag, and restores the delimiter defaults.
module length_prefixed_frame_deframer_top (
    input  logic i_clk,
    input  logic i_rst_n,
    ldf_byte_if.sink   i_in,
    ldf_res_if.source  o_out,
    ldf_cfg_if.sink    i_cfg
);
    import ldf_pkg::*;

    // Delimiter registers.
    logic [BYTE_W-1:0] r_start_one;
    logic [BYTE_W-1:0] r_start_two;
    logic [BYTE_W-1:0] r_stop;

    // Parser state.
    t_stage           r_stage, n_stage;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_len, n_len;
    logic [PC_W-1:0]  r_pc, n_pc;
    logic             r_ovf, n_ovf;

    // Result register.
    logic               r_out_valid;
    t_kind              r_kind;
    logic [BYTE_W-1:0]  r_byte;
    logic [INDEX_W-1:0] r_index;
    logic               r_trunc;

    // Result computed for the byte at the input.
    logic               res_valid;
    t_kind              res_kind;
    logic [BYTE_W-1:0]  res_byte;
    logic [INDEX_W-1:0] res_index;
    logic               res_trunc;

    logic              in_fire;
    logic [BYTE_W-1:0] b;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  data_end;
    logic              pay_room;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign b           = i_in.rx_byte;

    assign pos_inc  = r_pos + POS_W'(1);
    assign data_end = HEADER_SIZE + POS_W'(r_len) + POS_W'(1);
    assign pay_room = (r_pc < PC_W'(BUF_DEPTH));

    // Next stage of the parser.
    always_comb begin
        n_stage = r_stage;
        case (r_stage)
            ST_HUNT1: begin
                if (b == r_start_one) begin
                    n_stage = ST_HUNT2;
                end
            end
            ST_HUNT2: begin
                n_stage = (b == r_start_two) ? ST_LEN_LSB : ST_HUNT1;
            end
            ST_LEN_LSB: begin
                n_stage = ST_BODY;
            end
            ST_BODY: begin
                if (pos_inc >= HEADER_SIZE && pos_inc >= data_end) begin
                    n_stage = ST_HUNT1;
                end
            end
            default: begin
                n_stage = ST_HUNT1;
            end
        endcase
    end

    // Counters, length and the result for the current byte.
    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_pc      = r_pc;
        n_ovf     = r_ovf;
        res_valid = 1'b0;
        res_kind  = KIND_PAYLOAD;
        res_byte  = '0;
        res_index = '0;
        res_trunc = 1'b0;
        case (r_stage)
            ST_LEN_LSB: begin
                n_len = LEN_W'(b);
                n_pc  = '0;
                n_ovf = 1'b0;
                n_pos = POS_LEN_LSB;
            end
            ST_BODY: begin
                n_pos = pos_inc;
                if (pos_inc == POS_LEN_MSB) begin
                    n_len = {b, r_len[BYTE_W-1:0]};
                end else if (pos_inc == POS_TYPE
                             || (pos_inc >= HEADER_SIZE && pos_inc < data_end)) begin
                    // Type byte or data byte: emit while the buffer has room.
                    if (pay_room) begin
                        res_valid = 1'b1;
                        res_byte  = b;
                        res_index = INDEX_W'(r_pc);
                        n_pc      = r_pc + PC_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else if (pos_inc >= HEADER_SIZE) begin
                    // Stop position: report the frame outcome.
                    res_valid = 1'b1;
                    res_kind  = (b == r_stop) ? KIND_ACCEPT : KIND_REJECT;
                    res_trunc = r_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    // Delimiter register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_one <= START_ONE_RST;
            r_start_two <= START_TWO_RST;
            r_stop      <= STOP_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_START_ONE: r_start_one <= i_cfg.data;
                CFG_START_TWO: r_start_two <= i_cfg.data;
                CFG_STOP:      r_stop      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Parser state update on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_HUNT1;
            r_pos   <= '0;
            r_len   <= '0;
            r_pc    <= '0;
            r_ovf   <= 1'b0;
        end else if (in_fire) begin
            r_stage <= n_stage;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_pc    <= n_pc;
            r_ovf   <= n_ovf;
        end
    end

    // Result register: loads with each accepted byte, drains when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind  <= res_kind;
            r_byte  <= res_byte;
            r_index <= res_index;
            r_trunc <= res_trunc;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_kind  = r_kind;
    assign o_out.out_byte  = r_byte;
    assign o_out.out_index = r_index;
    assign o_out.truncated = r_trunc;

    // An end-of-frame report always sends the parser back to hunting.
    a_end_hunt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && res_valid && res_kind != KIND_PAYLOAD |=> r_stage == ST_HUNT1)
        else $error("parser did not return to hunting after frame end");

    // Every emitted payload byte advances the payload counter by one.
    a_pc_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && res_valid && res_kind == KIND_PAYLOAD
        |=> r_pc == $past(r_pc) + PC_W'(1))
        else $error("payload counter did not advance with a payload byte");

    // The payload counter saturates at the buffer depth.
    a_pc_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PC_W'(BUF_DEPTH))
        else $error("payload counter beyond buffer depth");

    // Taking the length LSB starts a fresh frame.
    a_new_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_stage == ST_LEN_LSB
        |=> r_pos == POS_LEN_LSB && r_pc == '0 && !r_ovf && r_stage == ST_BODY)
        else $error("frame counters not restarted at length byte");

endmodule

// File: tb/sv/length_prefixed_frame_deframer_top_test.sv
// Self-checking testbench for length_prefixed_frame_deframer_top: random and
// directed byte streams, a byte-level frame predictor and a scoreboard.
// Depends on ldf_pkg, ldf_if.sv and the deframer top level.
module length_prefixed_frame_deframer_top_test;
    import ldf_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_ITEMS    = 1950;
    localparam int RAND_PHASES    = 3;

    // One expected entry on the result channel.
    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] idx;
        logic               trunc;
    } frame_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ldf_byte_if byte_ch ();
    ldf_res_if  res_ch ();
    ldf_cfg_if  cfg_ch ();

    length_prefixed_frame_deframer_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Predictor copy of the delimiter registers and the parser state.
    logic [BYTE_W-1:0] cfg_sof1, cfg_sof2, cfg_eof;
    t_stage            dfr_stage;
    logic [POS_W-1:0]  dfr_pos;
    logic [LEN_W-1:0]  dfr_len;
    logic [7:0]        dfr_count;
    logic              dfr_ovf;

    frame_res_t pending_results [$];

    int  n_bytes      = 0;
    int  n_payload    = 0;
    int  n_accept     = 0;
    int  n_reject     = 0;
    int  n_trunc      = 0;
    int  n_settings   = 0;
    int  fail_count   = 0;
    int  quiet_cycles = 0;
    bit  tx_gaps_on   = 1'b1;
    bit  rx_stalls_on = 1'b1;
    bit  hold_request = 1'b0;

    function automatic void deframer_reset();
        cfg_sof1  = START_ONE_RST;
        cfg_sof2  = START_TWO_RST;
        cfg_eof   = STOP_RST;
        dfr_stage = ST_HUNT1;
        dfr_pos   = '0;
        dfr_len   = '0;
        dfr_count = '0;
        dfr_ovf   = 1'b0;
    endfunction

    // Payload bytes beyond the buffer depth are dropped and mark the frame.
    function automatic bit take_payload(input logic [BYTE_W-1:0] val, output frame_res_t r);
        r = '0;
        if (dfr_count >= BUF_DEPTH) begin
            dfr_ovf = 1'b1;
            return 1'b0;
        end
        r.kind    = KIND_PAYLOAD;
        r.data    = val;
        r.idx     = dfr_count[INDEX_W-1:0];
        dfr_count = dfr_count + 8'd1;
        return 1'b1;
    endfunction

    // Advances the predicted parser by one byte; returns 1 when a result is due.
    function automatic bit deframe_step(input logic [BYTE_W-1:0] val, output frame_res_t r);
        bit has;
        has = 1'b0;
        r   = '0;
        case (dfr_stage)
            ST_HUNT1: begin
                if (val == cfg_sof1)
                    dfr_stage = ST_HUNT2;
            end
            ST_HUNT2: begin
                dfr_stage = (val == cfg_sof2) ? ST_LEN_LSB : ST_HUNT1;
            end
            ST_LEN_LSB: begin
                dfr_len   = {8'h00, val};
                dfr_count = '0;
                dfr_ovf   = 1'b0;
                dfr_pos   = POS_LEN_LSB;
                dfr_stage = ST_BODY;
            end
            default: begin
                dfr_pos = dfr_pos + POS_W'(1);
                if (dfr_pos < HEADER_SIZE) begin
                    if (dfr_pos == POS_LEN_MSB)
                        dfr_len[15:8] = val;
                    else if (dfr_pos == POS_TYPE)
                        has = take_payload(val, r);
                end else if (int'(dfr_pos) < int'(HEADER_SIZE) + int'(dfr_len) + 1) begin
                    has = take_payload(val, r);
                end else begin
                    // Stop position: report the frame and go back to hunting.
                    r.kind    = (val == cfg_eof) ? KIND_ACCEPT : KIND_REJECT;
                    r.trunc   = dfr_ovf;
                    dfr_stage = ST_HUNT1;
                    has       = 1'b1;
                end
            end
        endcase
        return has;
    endfunction

    task automatic compare_field(input string name, input logic [BYTE_W-1:0] want,
                                 input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Scoreboard: check results first, then predict from the byte taken this edge.
    always @(posedge i_clk) begin : scoreboard
        frame_res_t exp_r;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result kind %0d byte %0d index %0d truncated %0b",
                             $time, res_ch.out_kind, res_ch.out_byte, res_ch.out_index,
                             res_ch.truncated);
                end else begin
                    exp_r = pending_results.pop_front();
                    compare_field("out_kind", BYTE_W'(exp_r.kind), BYTE_W'(res_ch.out_kind));
                    compare_field("out_byte", exp_r.data, res_ch.out_byte);
                    compare_field("out_index", BYTE_W'(exp_r.idx), BYTE_W'(res_ch.out_index));
                    compare_field("truncated", BYTE_W'(exp_r.trunc),
                                  BYTE_W'(res_ch.truncated));
                    case (exp_r.kind)
                        KIND_PAYLOAD: n_payload++;
                        KIND_ACCEPT:  n_accept++;
                        default:      n_reject++;
                    endcase
                    if (exp_r.trunc)
                        n_trunc++;
                end
            end
            if (byte_ch.valid && byte_ch.ready) begin
                n_bytes++;
                if (deframe_step(byte_ch.rx_byte, exp_r))
                    pending_results.push_back(exp_r);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_START_ONE: cfg_sof1 = cfg_ch.data;
                    CFG_START_TWO: cfg_sof2 = cfg_ch.data;
                    CFG_STOP:      cfg_eof  = cfg_ch.data;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: ends the run when no request moves on any channel for too long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("length_prefixed_frame_deframer_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Idle lengths: mostly a few cycles, now and then a long stretch.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result receiver: random stalls, plus a long hold-off when the test asks.
    initial begin : result_sink
        int   stall_left;
        int   hold_left;
        logic rdy;
        stall_left   = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                rdy = 1'b0;
                stall_left--;
            end else begin
                rdy = 1'b1;
                if (rx_stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
            res_ch.ready <= rdy;
        end
    end

    // Offers one byte, after an optional gap, and waits until the request is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] val);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            byte_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= val;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
    endtask

    // Whole frame with the current delimiters; fill < 0 means random content.
    task automatic send_frame(input int len, input int fill, input bit good_stop);
        logic [LEN_W-1:0]  l16;
        logic [BYTE_W-1:0] stop_val;
        l16      = LEN_W'(len);
        stop_val = good_stop ? cfg_eof : cfg_eof ^ BYTE_W'($urandom_range(1, 255));
        send_byte(cfg_sof1);
        send_byte(cfg_sof2);
        send_byte(l16[7:0]);
        send_byte(l16[15:8]);
        // Type byte followed by len + 1 data bytes.
        for (int i = 0; i < len + 2; i++)
            send_byte(fill < 0 ? BYTE_W'($urandom) : BYTE_W'(fill));
        send_byte(stop_val);
    endtask

    // Stops offering and waits until every expected result has been taken.
    task automatic wait_drained();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_delimiters(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                                  input logic [BYTE_W-1:0] eof);
        write_reg(CFG_START_ONE, s1);
        write_reg(CFG_START_TWO, s2);
        write_reg(CFG_STOP, eof);
        n_settings++;
    endtask

    // Reset delimiters: shortest frame of zeros accepted, all-ones frame rejected.
    task automatic test_default_delimiters();
        send_frame(0, 8'h00, 1'b1);
        send_frame(1, 8'hFF, 1'b0);
    endtask

    // A wrong second start byte drops back to hunting without rechecking it.
    task automatic test_false_start();
        send_byte(cfg_sof1);
        send_byte(cfg_sof1);
        send_byte(cfg_sof2);
        send_byte(8'h00);
        send_frame(2, -1, 1'b1);
    endtask

    // Payload right at the buffer depth, one past it, a length with the high
    // byte set, then a short frame to see the overflow flag cleared.
    task automatic test_buffer_overflow();
        send_frame(BUF_DEPTH - 2, -1, 1'b1);
        send_frame(BUF_DEPTH - 1, -1, 1'b1);
        send_frame(16'h0102, -1, 1'b0);
        send_frame(0, -1, 1'b1);
    endtask

    // Extreme and random delimiter values, including all three equal.
    task automatic test_delimiter_settings();
        logic [BYTE_W-1:0] s1, s2, eof;
        int k;
        for (k = 0; k < 5; k++) begin
            case (k)
                0: begin
                    s1 = 8'h00; s2 = 8'hFF; eof = 8'h00;
                end
                1: begin
                    s1 = 8'hFF; s2 = 8'h00; eof = 8'hFF;
                end
                2: begin
                    s1 = 8'h5A; s2 = 8'h5A; eof = 8'h5A;
                end
                default: begin
                    s1 = BYTE_W'($urandom); s2 = BYTE_W'($urandom); eof = BYTE_W'($urandom);
                end
            endcase
            wait_drained();
            set_delimiters(s1, s2, eof);
            send_frame($urandom_range(0, 6), -1, 1'b1);
            send_byte(cfg_sof1);
            send_byte(cfg_sof2 ^ 8'h80);
            send_frame(0, -1, 1'b0);
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_output_hold_off();
        hold_request = 1'b1;
        tx_gaps_on   = 1'b0;
        send_frame(60, -1, 1'b1);
        tx_gaps_on   = 1'b1;
    endtask

    // Sender pauses mid-frame until every expected result is out, then resumes.
    task automatic test_sender_pause();
        send_byte(cfg_sof1);
        send_byte(cfg_sof2);
        send_byte(8'd10);
        send_byte(8'd0);
        repeat (5) send_byte(BYTE_W'($urandom));
        wait_drained();
        repeat (7) send_byte(BYTE_W'($urandom));
        send_byte(cfg_eof);
    endtask

    // Mostly well-formed frames with random content and length, plus noise,
    // false starts and bad stop bytes, over several delimiter settings.
    // The random traffic fills up the byte budget left by the directed tests.
    task automatic test_random_traffic();
        int                start_count;
        int                budget;
        int                unit;
        int                sel;
        int                len;
        logic [BYTE_W-1:0] rx;
        start_count = n_bytes;
        budget      = TOTAL_ITEMS - start_count;
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            if (p == 0)
                set_delimiters(START_ONE_RST, START_TWO_RST, STOP_RST);
            else
                set_delimiters(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
            unit = 0;
            while (n_bytes - start_count < budget * (p + 1) / RAND_PHASES) begin
                // Switch idling on and off in stretches.
                if (unit % 16 == 0) begin
                    tx_gaps_on   = $urandom_range(0, 2) != 0;
                    rx_stalls_on = $urandom_range(0, 2) != 0;
                end
                sel = $urandom_range(0, 99);
                if (sel < 75) begin
                    if ($urandom_range(0, 19) == 0)
                        len = ($urandom_range(0, 3) == 0) ? 256 + $urandom_range(0, 40)
                                                          : $urandom_range(120, 140);
                    else
                        len = $urandom_range(0, 15);
                    send_frame(len, -1, $urandom_range(0, 6) != 0);
                end else if (sel < 88) begin
                    // Line noise that never looks like a first start byte.
                    repeat ($urandom_range(1, 5)) begin
                        rx = BYTE_W'($urandom);
                        if (rx == cfg_sof1)
                            rx ^= 8'h01;
                        send_byte(rx);
                    end
                end else begin
                    rx = BYTE_W'($urandom);
                    if (rx == cfg_sof2)
                        rx = ~rx;
                    send_byte(cfg_sof1);
                    send_byte(rx);
                end
                unit++;
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial begin : stimulus
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_START_ONE;
        cfg_ch.data     = '0;
        i_rst_n         = 1'b0;
        deframer_reset();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_delimiters();
        test_false_start();
        test_buffer_overflow();
        test_delimiter_settings();
        test_output_hold_off();
        test_sender_pause();
        test_random_traffic();
        wait_drained();

        $display("Run covered %0d bytes over %0d delimiter settings and a %0d-cycle hold-off.",
                 n_bytes, n_settings, HOLD_CYCLES);
        $display("Results checked: %0d payload, %0d accepted, %0d rejected, %0d truncated.",
                 n_payload, n_accept, n_reject, n_trunc);
        if (fail_count == 0)
            $display("length_prefixed_frame_deframer_top: match");
        else
            $display("length_prefixed_frame_deframer_top: mismatch");
        $finish;
    end

endmodule

// File: sim.f
design/ldf_pkg.sv
design/ldf_if.sv
design/length_prefixed_frame_deframer_top.sv
tb/sv/length_prefixed_frame_deframer_top_test.sv
